[hw/rtl/esc_pkg.sv]
// esc_pkg: types and helpers shared by the compensation datapath
// no dependencies
package esc_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned CfgW  = 64;
  localparam int unsigned IdxW  = 3;

  typedef enum logic [IdxW-1:0] {
    REG_TEMP    = 3'd0,
    REG_PRESS_A = 3'd1,
    REG_PRESS_B = 3'd2,
    REG_PRESS_C = 3'd3,
    REG_HUM     = 3'd4
  } reg_idx_e;

  typedef logic [WordW-1:0] word_t;

  // pressure division request carried down the divider pipe
  typedef struct packed {
    logic  valid;
    logic  big;   // dividend was >= 2^31: divide then double
    logic  dz;
    word_t num;
    word_t den;
  } div_req_t;

  // 32-bit wrapping multiply
  function automatic word_t mul32(word_t a, word_t b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

  function automatic word_t asr(word_t x, int unsigned n);
    return word_t'($signed(x) >>> n);
  endfunction

endpackage

[hw/rtl/esc_divider.sv]
// esc_divider: pipelined unsigned 32/32 restoring divider, four bits per stage
// depends on esc_pkg
module esc_divider import esc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     adv_i,
  input  div_req_t req_i,
  output logic     valid_o,
  output logic     dz_o,
  output word_t    quot_o,
  output logic     big_o
);
  localparam int unsigned Stages = 8;
  localparam int unsigned Step   = WordW / Stages;

  logic [Stages:1]  vld_q;
  logic [Stages:1]  big_q;
  logic [Stages:1]  dz_q;
  word_t            num_q [1:Stages];
  word_t            den_q [1:Stages];
  logic [WordW:0]   rem_q [1:Stages];

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic           vld_in, big_in, dz_in;
    word_t          num_in, den_in;
    logic [WordW:0] rem_in;
    logic [WordW:0] rem_d;
    word_t          num_d;
    if (s == 0) begin : g_head
      assign vld_in = req_i.valid;
      assign big_in = req_i.big;
      assign dz_in  = req_i.dz;
      assign num_in = req_i.num;
      assign den_in = req_i.den;
      assign rem_in = '0;
    end else begin : g_body
      assign vld_in = vld_q[s];
      assign big_in = big_q[s];
      assign dz_in  = dz_q[s];
      assign num_in = num_q[s];
      assign den_in = den_q[s];
      assign rem_in = rem_q[s];
    end
    always_comb begin
      rem_d = rem_in;
      num_d = num_in;
      for (int k = 0; k < Step; k++) begin
        rem_d = {rem_d[WordW-1:0], num_d[WordW-1]};
        num_d = {num_d[WordW-2:0], 1'b0};
        if (rem_d >= {1'b0, den_in}) begin
          rem_d = rem_d - {1'b0, den_in};
          num_d[0] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else if (adv_i) begin
        vld_q[s+1] <= vld_in;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        big_q[s+1] <= big_in;
        dz_q[s+1]  <= dz_in;
        num_q[s+1] <= num_d;
        den_q[s+1] <= den_in;
        rem_q[s+1] <= rem_d;
      end
    end
  end

  assign valid_o = vld_q[Stages];
  assign dz_o    = dz_q[Stages];
  assign quot_o  = num_q[Stages];
  assign big_o   = big_q[Stages];
endmodule

[hw/rtl/environment_sensor_compensation_core.sv]
// environment_sensor_compensation_core: top level of the compensation pipeline
// depends on esc_pkg and esc_divider
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  in      | in_valid_i/stall_o  | raw_temperature/pressure/humidity
//  out     | out_valid_o/stall_i | temperature_centi, pressure_pa, humid..
//  cfg     | cfg_we_i            | cfg_idx_i, cfg_data_i
//
// one beat per cycle while the output is not stalled; the pipe holds 6 front stages
// (at most one multiply deep each), 8 divider stages of four quotient
// bits, one pressure correction stage and the output register. the whole
// pipe advances together whenever the output register is empty or being
// taken, so a stall freezes every stage in place. reset clears valid bits
// and coefficient registers.
module environment_sensor_compensation_core import esc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [19:0]       raw_temperature_i,
  input  logic [19:0]       raw_pressure_i,
  input  logic [15:0]       raw_humidity_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic signed [31:0] temperature_centi_o,
  output logic [31:0]       pressure_pa_o,
  output logic [16:0]       humidity_q10_o,
  output logic              pressure_div_zero_o,
  input  logic              cfg_we_i,
  input  logic [IdxW-1:0]   cfg_idx_i,
  input  logic [CfgW-1:0]   cfg_data_i
);

  // coefficient registers
  logic [47:0] tc_q, pa_q, pb_q, pc_q;
  logic [63:0] hc_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tc_q <= '0; pa_q <= '0; pb_q <= '0; pc_q <= '0; hc_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TEMP:    tc_q <= cfg_data_i[47:0];
        REG_PRESS_A: pa_q <= cfg_data_i[47:0];
        REG_PRESS_B: pb_q <= cfg_data_i[47:0];
        REG_PRESS_C: pc_q <= cfg_data_i[47:0];
        REG_HUM:     hc_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  word_t t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  word_t h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, tc_q[15:0]};
  assign t2 = word_t'($signed(tc_q[31:16]));
  assign t3 = word_t'($signed(tc_q[47:32]));
  assign p1 = {16'd0, pa_q[15:0]};
  assign p2 = word_t'($signed(pa_q[31:16]));
  assign p3 = word_t'($signed(pa_q[47:32]));
  assign p4 = word_t'($signed(pb_q[15:0]));
  assign p5 = word_t'($signed(pb_q[31:16]));
  assign p6 = word_t'($signed(pb_q[47:32]));
  assign p7 = word_t'($signed(pc_q[15:0]));
  assign p8 = word_t'($signed(pc_q[31:16]));
  assign p9 = word_t'($signed(pc_q[47:32]));
  assign h1 = {24'd0, hc_q[7:0]};
  assign h2 = word_t'($signed(hc_q[23:8]));
  assign h3 = {24'd0, hc_q[31:24]};
  assign h4 = word_t'($signed(hc_q[43:32]));
  assign h5 = word_t'($signed(hc_q[55:44]));
  assign h6 = word_t'($signed(hc_q[63:56]));

  // whole pipe moves as one when the output slot frees up
  logic adv;
  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  // stage valid bits
  logic [6:1] v_q;
  logic       div_v, div_dz, div_big;
  word_t      div_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[5:1], in_valid_i};
    end
  end

  // stage 1: temperature products
  word_t s1_ta, s1_dd, s1_rp, s1_rh;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ta <= mul32({15'd0, raw_temperature_i[19:3]} - (t1 << 1), t2);
      s1_dd <= mul32({16'd0, raw_temperature_i[19:4]} - t1,
                     {16'd0, raw_temperature_i[19:4]} - t1);
      s1_rp <= {12'd0, raw_pressure_i};
      s1_rh <= {16'd0, raw_humidity_i};
    end
  end

  // stage 2: fine temperature
  word_t s2_fine, s2_rp, s2_rh;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_fine <= asr(s1_ta, 11) + asr(mul32(asr(s1_dd, 12), t3), 14);
      s2_rp   <= s1_rp;
      s2_rh   <= s1_rh;
    end
  end

  // stage 3: temperature result, first pressure and humidity products
  word_t s3_temp, s3_dd, s3_ap5, s3_p2a, s3_rp;
  word_t s3_h5v, s3_vh6, s3_vh3, s3_rh;
  always_ff @(posedge clk_i) begin
    word_t a, d, v;
    a = asr(s2_fine, 1) - 32'd64000;
    d = asr(a, 2);
    v = s2_fine - 32'd76800;
    if (adv) begin
      s3_temp <= asr(mul32(s2_fine, 32'd5) + 32'd128, 8);
      s3_dd   <= mul32(d, d);
      s3_ap5  <= mul32(a, p5);
      s3_p2a  <= mul32(p2, a);
      s3_rp   <= s2_rp;
      s3_h5v  <= mul32(h5, v);
      s3_vh6  <= mul32(v, h6);
      s3_vh3  <= mul32(v, h3);
      s3_rh   <= s2_rh;
    end
  end

  // stage 4
  word_t s4_temp, s4_b, s4_a, s4_rp, s4_ha, s4_b6, s4_d3;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_temp <= s3_temp;
      s4_b    <= mul32(asr(s3_dd, 11), p6) + (s3_ap5 << 1);
      s4_a    <= asr(asr(mul32(p3, asr(s3_dd, 13)), 3) + asr(s3_p2a, 1), 18);
      s4_rp   <= s3_rp;
      s4_ha   <= asr(((s3_rh << 14) - (h4 << 20) - s3_h5v) + 32'd16384, 15);
      s4_b6   <= asr(s3_vh6, 10);
      s4_d3   <= asr(s3_vh3, 11) + 32'd32768;
    end
  end

  // stage 5
  word_t s5_temp, s5_b, s5_den, s5_rp, s5_ha, s5_bh;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_temp <= s4_temp;
      s5_b    <= asr(s4_b, 2) + (p4 << 16);
      s5_den  <= asr(mul32(32'd32768 + s4_a, p1), 15);
      s5_rp   <= s4_rp;
      s5_ha   <= s4_ha;
      s5_bh   <= asr(mul32(s4_b6, s4_d3), 10) + 32'd2097152;
    end
  end

  // stage 6: dividend, humidity scale
  word_t s6_temp, s6_num, s6_den, s6_ha, s6_hb;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_temp <= s5_temp;
      s6_num  <= mul32((32'd1048576 - s5_rp) - asr(s5_b, 12), 32'd3125);
      s6_den  <= s5_den;
      s6_ha   <= s5_ha;
      s6_hb   <= asr(mul32(s5_bh, h2) + 32'd8192, 14);
    end
  end

  // stage 7: humidity product, divider launch
  word_t s7_v;
  div_req_t req;
  always_comb begin
    req.valid = v_q[6];
    req.dz    = (s6_den == '0);
    req.big   = s6_num[31];
    req.num   = s6_num[31] ? s6_num : (s6_num << 1);
    req.den   = s6_den;
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_v <= mul32(s6_ha, s6_hb);
    end
  end

  // stage 8: humidity square term
  word_t s8_v, s8_dd;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_v  <= s7_v;
      s8_dd <= asr(mul32(asr(s7_v, 15), asr(s7_v, 15)), 7);
    end
  end

  // humidity and temperature ride alongside the divider
  localparam int unsigned Lag = 8;
  word_t      tq_q [Lag+1];
  word_t      hq_q [Lag-1];
  logic [16:0] hum_fin;
  always_comb begin
    word_t v;
    v = s8_v - asr(mul32(s8_dd, h1), 4);
    if (v[31]) v = '0;
    if (v > 32'd419430400) v = 32'd419430400;
    hum_fin = v[28:12];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      tq_q[0] <= s6_temp;
      hq_q[0] <= {15'd0, hum_fin};
      for (int i = 1; i < Lag-1; i++) hq_q[i] <= hq_q[i-1];
      for (int i = 1; i <= Lag; i++) tq_q[i] <= tq_q[i-1];
    end
  end

  esc_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .req_i   (req),
    .valid_o (div_v),
    .dz_o    (div_dz),
    .quot_o  (div_q),
    .big_o   (div_big)
  );

  // pressure correction stage: squared and p8 terms
  word_t pq;
  logic  cr_v_q, cr_dz_q;
  word_t cr_p_q, cr_sq_q, cr_pb_q;
  assign pq = div_big ? (div_q << 1) : div_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cr_v_q <= 1'b0;
    end else if (adv) begin
      cr_v_q <= div_v;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      cr_dz_q <= div_dz;
      cr_p_q  <= pq;
      cr_sq_q <= mul32({3'd0, pq[31:3]}, {3'd0, pq[31:3]}) >> 13;
      cr_pb_q <= asr(mul32({2'd0, pq[31:2]}, p8), 13);
    end
  end

  // final pressure sum and output register
  word_t pf, pa;
  always_comb begin
    pa = asr(mul32(p9, cr_sq_q), 12);
    pf = cr_dz_q ? '0 : cr_p_q + asr(pa + cr_pb_q + p7, 4);
  end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= cr_v_q;
    end
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      temperature_centi_o <= $signed(tq_q[Lag]);
      pressure_pa_o       <= pf;
      humidity_q10_o      <= hq_q[Lag-2][16:0];
      pressure_div_zero_o <= cr_dz_q;
    end
  end
endmodule
